// ----- hw/rtl/rc4_stream_cipher_unit_assert.svh -----
// ----------------------------------------------------------------------------
// rc4 stream cipher assertion macros
// concurrent assertions clocked on clk and disabled while arst_n is low;
// they compile to nothing when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_UNIT_ASSERT_SVH
`define RC4_STREAM_CIPHER_UNIT_ASSERT_SVH

`ifndef SYNTH
// property holds at every clock edge
`define RC4_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("rc4 assertion failed");
// consequent holds in the cycle after the antecedent
`define RC4_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rc4 assertion failed");
`else
`define RC4_ASSERT(lbl, prop)
`define RC4_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/rc4_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 package
// shared types and constants of the rc4 stream cipher unit
// ----------------------------------------------------------------------------
package rc4_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [8:0] count_t;

	localparam int    PERM_DEPTH = 256;
	localparam byte_t PERM_LAST  = 8'hFF;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_READ_J = 8'b0000_0010,
		ST_SWAP_I = 8'b0000_0100,
		ST_FINISH = 8'b0000_1000,
		ST_KS_A   = 8'b0001_0000,
		ST_KS_B   = 8'b0010_0000,
		ST_KS_C   = 8'b0100_0000,
		ST_KS_W   = 8'b1000_0000
	} state_t;

endpackage

// ----- hw/rtl/rc4_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 input channel
// valid/ready channel carrying one key or data byte per item
// ----------------------------------------------------------------------------
interface rc4_in_if;

	logic          valid;
	logic          ready;
	logic          kind;
	rc4_pkg::byte_t byte_in;
	logic          last;

	modport source (output valid, output kind, output byte_in, output last, input ready);
	modport sink   (input valid, input kind, input byte_in, input last, output ready);

endinterface

// ----- hw/rtl/rc4_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 output channel
// valid/ready channel carrying one enciphered byte per item
// ----------------------------------------------------------------------------
interface rc4_out_if;

	logic          valid;
	logic          ready;
	rc4_pkg::byte_t byte_out;
	logic          last_out;

	modport source (output valid, output byte_out, output last_out, input ready);
	modport sink   (input valid, input byte_out, input last_out, output ready);

endinterface

// ----- hw/rtl/rc4_stream_cipher_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 stream cipher unit
// byte-wide rc4 cipher with key store, key schedule and keystream generator
// ----------------------------------------------------------------------------
// Key bytes (kind 0) are written to the key store at one byte per cycle; the
// key byte marked last starts the key schedule, 256 swap steps through
// ST_KS_A, ST_KS_B and ST_KS_C plus a final write, during which no item is taken.
// A data byte (kind 1) passes through ST_READ_J, ST_SWAP_I and ST_FINISH, and
// its result is registered on leaving ST_FINISH once the output slot is free;
// the next item can be taken in ST_FINISH when the slot is free, so a result
// waits in an output register while the next item is already at work. The
// pacing is set by the permutation memory, which has one read port and one
// write port, so the reads of s[i], s[j] and s[s[i]+s[j]] and the two swap
// writes are spread over the states. Data sent before any key uses the identity
// permutation, and the keystream runs on across messages until a new key is scheduled.
`include "rc4_stream_cipher_unit_assert.svh"

module rc4_stream_cipher_unit #(
	parameter int KEY_MAX = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	rc4_in_if.sink    din,
	rc4_out_if.source dout
);
	import rc4_pkg::*;

	state_t state_q, state_d;

	// permutation memory, one read and one write port, with valid bits
	byte_t                 perm_mem [PERM_DEPTH];
	logic [PERM_DEPTH-1:0] perm_vld_q;
	logic                  perm_re, perm_we, perm_clr;
	byte_t                 perm_ra, perm_wa, perm_wd;
	byte_t                 perm_rd_s1, perm_rd_addr_s1, perm_rd;
	logic                  perm_rd_vld_s1;

	// key store
	byte_t key_mem [PERM_DEPTH];
	logic  key_re, key_we;
	byte_t key_ra, key_wa, key_rd_s1;

	byte_t  i_q, j_q, n_q, k_q;
	byte_t  a_q, sum_q, t_q, data_q;
	logic   last_q;
	count_t key_cnt_q, cnt_eff, cnt_next;
	logic   key_open_q;
	logic   out_valid_q, out_last_q;
	byte_t  out_byte_q;

	logic   accept, slot_free;
	state_t nxt_accept;
	byte_t  ks_byte, ks_j, k_next;

	assign accept    = din.valid && din.ready;
	assign slot_free = !out_valid_q || dout.ready;
	assign din.ready = (state_q == ST_IDLE) || (state_q == ST_FINISH && slot_free);

	assign dout.valid    = out_valid_q;
	assign dout.byte_out = out_byte_q;
	assign dout.last_out = out_last_q;

	// entry never written since identity reads as its own index
	assign perm_rd = perm_rd_vld_s1 ? perm_rd_s1 : perm_rd_addr_s1;

	// key write bookkeeping, a closed key restarts the count
	assign cnt_eff  = key_open_q ? key_cnt_q : '0;
	assign key_we   = accept && !din.kind && (cnt_eff < count_t'(KEY_MAX));
	assign key_wa   = cnt_eff[7:0];
	assign cnt_next = key_we ? cnt_eff + count_t'(1) : cnt_eff;
	assign perm_clr = accept && !din.kind && din.last;

	assign nxt_accept = din.kind ? ST_READ_J : (din.last ? ST_KS_A : ST_IDLE);

	// j1 holds a after the swap, so that entry is forwarded here
	assign ks_byte = (sum_q == j_q) ? a_q : perm_rd;
	assign ks_j    = j_q + key_rd_s1 + perm_rd;
	assign k_next  = (({1'b0, k_q} + count_t'(1)) >= key_cnt_q) ? '0 : k_q + 8'd1;

	always_comb begin
		perm_re = 1'b0;
		perm_we = 1'b0;
		perm_ra = i_q + 8'd1;
		perm_wa = j_q;
		perm_wd = a_q;
		key_re  = 1'b0;
		key_ra  = k_q;
		unique case (state_q)
			ST_IDLE: begin
				perm_re = accept && din.kind;
			end
			ST_READ_J: begin
				perm_re = 1'b1;
				perm_ra = j_q + perm_rd;
			end
			ST_SWAP_I: begin
				perm_we = 1'b1;
				perm_wa = i_q;
				perm_wd = perm_rd;
				perm_re = 1'b1;
				perm_ra = a_q + perm_rd;
			end
			ST_FINISH: begin
				perm_we = 1'b1;
				perm_re = accept && din.kind;
			end
			ST_KS_A: begin
				// second write of the previous swap step
				perm_we = (n_q != 8'd0);
				perm_wd = t_q;
				perm_re = 1'b1;
				perm_ra = n_q;
				key_re  = 1'b1;
			end
			ST_KS_B: begin
				perm_re = 1'b1;
				perm_ra = ks_j;
			end
			ST_KS_C: begin
				perm_we = 1'b1;
				perm_wa = n_q;
				perm_wd = perm_rd;
			end
			ST_KS_W: begin
				perm_we = 1'b1;
				perm_wd = t_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = nxt_accept;
			ST_READ_J: state_d = ST_SWAP_I;
			ST_SWAP_I: state_d = ST_FINISH;
			ST_FINISH: if (slot_free) state_d = accept ? nxt_accept : ST_IDLE;
			ST_KS_A:   state_d = ST_KS_B;
			ST_KS_B:   state_d = ST_KS_C;
			ST_KS_C:   state_d = (n_q == PERM_LAST) ? ST_KS_W : ST_KS_A;
			ST_KS_W:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// permutation memory with write-through on a same-entry read
	always_ff @(posedge clk) begin
		if (perm_we) perm_mem[perm_wa] <= perm_wd;
		if (perm_re) begin
			perm_rd_addr_s1 <= perm_ra;
			if (perm_we && perm_wa == perm_ra) begin
				perm_rd_s1     <= perm_wd;
				perm_rd_vld_s1 <= 1'b1;
			end else begin
				perm_rd_s1     <= perm_mem[perm_ra];
				perm_rd_vld_s1 <= perm_vld_q[perm_ra];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_vld_q <= '0;
		end else if (perm_clr) begin
			perm_vld_q <= '0;
		end else if (perm_we) begin
			perm_vld_q[perm_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) key_mem[key_wa] <= din.byte_in;
		if (key_re) key_rd_s1 <= key_mem[key_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			k_q         <= '0;
			key_cnt_q   <= '0;
			key_open_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FINISH && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (dout.valid && dout.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (din.kind) begin
					key_open_q <= 1'b0;
					i_q        <= i_q + 8'd1;
				end else begin
					key_open_q <= !din.last;
					key_cnt_q  <= cnt_next;
					if (din.last) begin
						i_q <= '0;
						j_q <= '0;
						n_q <= '0;
						k_q <= '0;
					end
				end
			end
			unique case (state_q)
				ST_READ_J: j_q <= j_q + perm_rd;
				ST_KS_B:   j_q <= ks_j;
				ST_KS_C: begin
					n_q <= n_q + 8'd1;
					k_q <= k_next;
				end
				ST_KS_W:   j_q <= '0;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= din.byte_in;
			last_q <= din.last;
		end
		if (state_q == ST_READ_J) a_q <= perm_rd;
		if (state_q == ST_SWAP_I) sum_q <= a_q + perm_rd;
		if (state_q == ST_KS_B) t_q <= perm_rd;
		if (state_q == ST_FINISH && slot_free) begin
			out_byte_q <= data_q ^ ks_byte;
			out_last_q <= last_q;
		end
	end

	`RC4_ASSERT(a_data_result, (accept && din.kind) |-> ##4 dout.valid)
	`RC4_ASSERT(a_out_from_finish, $rose(dout.valid) |-> ($past(state_q) == ST_FINISH))
	`RC4_ASSERT_NEXT(a_ks_end_clears, state_q == ST_KS_W, state_q == ST_IDLE && i_q == '0 && j_q == '0)
	`RC4_ASSERT(a_key_cnt_bound, key_cnt_q <= count_t'(KEY_MAX))

endmodule

// ----- dv/rc4_stream_cipher_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 stream cipher unit test
// drives key and data bytes through the input channel, predicts every cipher
// byte with a local copy of the permutation, indices and key store, and
// compares each output item in order; a directed table comes first, then
// random key/message sequences with idle cycles and one long output hold-off
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit_test;

	import rc4_pkg::*;

	localparam int          KEY_LIMIT   = 256;
	localparam logic        KIND_KEY    = 1'b0;
	localparam logic        KIND_DATA   = 1'b1;
	localparam int          RAND_ITEMS  = 1200;
	localparam int          HOLD_CYCLES = 400;
	localparam int          DRAIN       = 20;
	localparam int unsigned LIMIT       = 1000000;

	typedef struct packed {
		byte_t value;
		logic  last;
	} cipher_byte_t;

	typedef struct packed {
		logic  kind;
		byte_t value;
		logic  last;
		logic  typed;
		byte_t exp_value;
		logic  exp_last;
	} table_row_t;

	logic clk;
	logic arst_n;

	rc4_in_if  din_ch ();
	rc4_out_if dout_ch ();

	rc4_stream_cipher_unit #(
		.KEY_MAX (KEY_LIMIT)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	// local cipher state
	byte_t  perm_s  [PERM_DEPTH];
	byte_t  key_mem [PERM_DEPTH];
	count_t key_len;
	byte_t  idx_i;
	byte_t  idx_j;
	logic   key_loading;

	cipher_byte_t pending_bytes [$];
	table_row_t   dir_rows [24];

	int          mismatches;
	int unsigned cycle_count;
	int          items_sent;
	bit          steady;
	bit          hold_request;
	int          hold_left;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic void reset_cipher();
		for (int n = 0; n < PERM_DEPTH; n++) begin
			perm_s[n]  = byte_t'(n);
			key_mem[n] = '0;
		end
		key_len     = '0;
		idx_i       = '0;
		idx_j       = '0;
		key_loading = 1'b0;
	endfunction

	function automatic void schedule_key();
		int unsigned k;
		int unsigned len;
		byte_t       t;
		byte_t       jj;
		len = (key_len == 0) ? 1 : key_len;
		k   = 0;
		jj  = '0;
		idx_i = '0;
		idx_j = '0;
		for (int n = 0; n < PERM_DEPTH; n++)
			perm_s[n] = byte_t'(n);
		for (int n = 0; n < PERM_DEPTH; n++) begin
			t         = perm_s[n];
			jj        = jj + key_mem[k] + t;
			perm_s[n] = perm_s[jj];
			perm_s[jj] = t;
			k++;
			if (k >= len)
				k = 0;
		end
	endfunction

	// returns 1 when the item gives a cipher byte
	function automatic logic cipher_step(input logic kind, input byte_t b, input logic lst,
			output cipher_byte_t res);
		byte_t a;
		byte_t c;
		byte_t sum;
		res = '0;
		if (kind == KIND_KEY) begin
			if (!key_loading) begin
				key_len     = '0;
				key_loading = 1'b1;
			end
			if (key_len < KEY_LIMIT) begin
				key_mem[key_len[7:0]] = b;
				key_len++;
			end
			if (lst) begin
				schedule_key();
				key_loading = 1'b0;
			end
			return 1'b0;
		end
		// data abandons any partial key
		key_loading   = 1'b0;
		idx_i         = idx_i + 8'd1;
		a             = perm_s[idx_i];
		idx_j         = idx_j + a;
		c             = perm_s[idx_j];
		perm_s[idx_i] = c;
		perm_s[idx_j] = a;
		sum           = a + c;
		res.value     = b ^ perm_s[sum];
		res.last      = lst;
		return 1'b1;
	endfunction

	task automatic send_item(input logic kind, input byte_t b, input logic lst,
			input logic typed, input cipher_byte_t typed_res);
		cipher_byte_t res;
		while (!steady && $urandom_range(99) < 6) begin
			din_ch.valid <= 1'b0;
			@(posedge clk);
		end
		din_ch.valid   <= 1'b1;
		din_ch.kind    <= kind;
		din_ch.byte_in <= b;
		din_ch.last    <= lst;
		do
			@(posedge clk);
		while (!din_ch.ready);
		items_sent++;
		if (cipher_step(kind, b, lst, res))
			pending_bytes.push_back(typed ? typed_res : res);
	endtask

	task automatic send_key(input int len, input logic close);
		for (int n = 0; n < len; n++)
			send_item(KIND_KEY, byte_t'($urandom), close && (n == len - 1), 1'b0, '0);
	endtask

	task automatic send_message(input int len);
		for (int n = 0; n < len; n++)
			send_item(KIND_DATA, byte_t'($urandom), n == len - 1, 1'b0, '0);
	endtask

	// output side: check accepted items, then pick ready for the next cycle
	initial begin
		dout_ch.ready = 1'b0;
		hold_left     = 0;
		forever begin
			@(posedge clk);
			if (arst_n && dout_ch.valid && dout_ch.ready) begin
				if (pending_bytes.size() == 0) begin
					$display("%0t unexpected item: expected none, actual byte %h last %b",
						$realtime, dout_ch.byte_out, dout_ch.last_out);
					mismatches++;
				end else begin
					if (dout_ch.byte_out !== pending_bytes[0].value) begin
						$display("%0t byte_out mismatch: expected %h actual %h",
							$realtime, pending_bytes[0].value, dout_ch.byte_out);
						mismatches++;
					end
					if (dout_ch.last_out !== pending_bytes[0].last) begin
						$display("%0t last_out mismatch: expected %b actual %b",
							$realtime, pending_bytes[0].last, dout_ch.last_out);
						mismatches++;
					end
					void'(pending_bytes.pop_front());
				end
			end
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (!arst_n) begin
				dout_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				dout_ch.ready <= 1'b0;
			end else begin
				dout_ch.ready <= steady || ($urandom_range(99) >= 6);
			end
		end
	end

	initial begin
		int           seq;
		int           pick;
		int           key_bytes;
		int           msgs;
		cipher_byte_t typed_res;

		mismatches     = 0;
		cycle_count    = 0;
		items_sent     = 0;
		steady         = 1'b0;
		hold_request   = 1'b0;
		arst_n         = 1'b0;
		din_ch.valid   = 1'b0;
		din_ch.kind    = KIND_KEY;
		din_ch.byte_in = '0;
		din_ch.last    = 1'b0;
		reset_cipher();

		// first two data bytes run on the identity permutation: keystream 02, 05
		dir_rows = '{
			'{KIND_DATA, 8'h00, 1'b0, 1'b1, 8'h02, 1'b0},
			'{KIND_DATA, 8'hFF, 1'b1, 1'b1, 8'hFA, 1'b1},
			'{KIND_DATA, 8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
			'{KIND_KEY,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
			'{KIND_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
			'{KIND_DATA, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
			'{KIND_KEY,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
			'{KIND_KEY,  8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
			'{KIND_KEY,  8'h01, 1'b1, 1'b0, 8'h00, 1'b0},
			'{KIND_DATA, 8'hA5, 1'b0, 1'b0, 8'h00, 1'b0},
			'{KIND_DATA, 8'h5A, 1'b1, 1'b0, 8'h00, 1'b0},
			'{KIND_KEY,  8'h12, 1'b0, 1'b0, 8'h00, 1'b0},
			'{KIND_KEY,  8'h34, 1'b0, 1'b0, 8'h00, 1'b0},
			'{KIND_DATA, 8'h0F, 1'b0, 1'b0, 8'h00, 1'b0},
			'{KIND_DATA, 8'hF0, 1'b1, 1'b0, 8'h00, 1'b0},
			'{KIND_KEY,  8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
			'{KIND_KEY,  8'h4B, 1'b0, 1'b0, 8'h00, 1'b0},
			'{KIND_KEY,  8'h65, 1'b0, 1'b0, 8'h00, 1'b0},
			'{KIND_KEY,  8'h79, 1'b1, 1'b0, 8'h00, 1'b0},
			'{KIND_DATA, 8'h50, 1'b0, 1'b0, 8'h00, 1'b0},
			'{KIND_DATA, 8'h6C, 1'b0, 1'b0, 8'h00, 1'b0},
			'{KIND_DATA, 8'h61, 1'b1, 1'b0, 8'h00, 1'b0},
			'{KIND_KEY,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
			'{KIND_DATA, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			typed_res.value = dir_rows[r].exp_value;
			typed_res.last  = dir_rows[r].exp_last;
			send_item(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].last,
				dir_rows[r].typed, typed_res);
		end

		items_sent = 0;
		seq        = 0;
		while (items_sent < RAND_ITEMS) begin
			seq++;
			steady = (items_sent >= 500) && (items_sent < 750);
			// the special sequences always take the full key path
			pick   = (seq == 2 || seq == 4 || seq == 9) ? 99 : $urandom_range(99);
			if (pick < 8) begin
				// lone data byte with random last flag
				send_item(KIND_DATA, byte_t'($urandom), 1'($urandom), 1'b0, '0);
			end else if (pick < 15) begin
				// partial key dropped by data
				send_key($urandom_range(1, 8), 1'b0);
				send_message($urandom_range(1, 20));
			end else begin
				if (seq == 4)
					key_bytes = $urandom_range(KEY_LIMIT + 1, 300);
				else if (seq == 9)
					key_bytes = KEY_LIMIT;
				else if ($urandom_range(99) < 3)
					key_bytes = $urandom_range(200, 300);
				else
					key_bytes = $urandom_range(1, 16);
				send_key(key_bytes, 1'b1);
				if (seq == 2)
					hold_request = 1'b1;
				msgs = $urandom_range(1, 3);
				for (int m = 0; m < msgs; m++)
					send_message((seq == 2) ? 60 : $urandom_range(1, 30));
			end
		end
		din_ch.valid <= 1'b0;
		steady = 1'b0;

		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
